// ----- hdl/lsst_pkg.sv -----
// ---------------------------------------------------------------------------
// lsst_pkg
// Shared constants and types for the load switch with soft start and trip.
// ---------------------------------------------------------------------------
package lsst_pkg;

    localparam int unsigned CUR_W   = 16;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned PULSE_W = 5;

    localparam logic [PULSE_W-1:0] SOFT_START_PULSES = 5'd20;
    localparam logic [CNT_W-1:0]   TRIP_TICKS        = 7'd100;
    localparam logic [CNT_W-1:0]   RESTART_DELAY     = 7'd100;
    localparam logic [CNT_W-1:0]   OVER_COUNT_MAX    = 7'd127;
    localparam logic [CUR_W-1:0]   CURRENT_LIMIT_RST = 16'd100;

    typedef enum logic [2:0] {
        PH_WAIT  = 3'd0,
        PH_PULSE = 3'd1,
        PH_FINAL = 3'd2,
        PH_OFF   = 3'd3,
        PH_RUN   = 3'd4
    } t_phase;

endpackage

// ----- hdl/load_switch_soft_start_trip.sv -----
// ---------------------------------------------------------------------------
// load_switch_soft_start_trip
// Load switch controller: pulsed soft start, over-current trip, hiccup
// restart and peak current tracking. One request is one control tick.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// tick      in         i_valid / o_ready       enable_request, measured_current
// result    out        o_valid / i_ready       power_on, phase, peak_current,
//                                              over_limit_ticks
// config    in         i_cfg_wr_en             i_cfg_wr_data (current limit)
//
// A request is captured in an input register and evaluated in the next cycle
// into the controller state, which is also the result register. One request
// is taken every cycle; the input register only waits, and evaluation with it,
// while a finished result is held by the output side. Reset is synchronous and
// returns the controller to waiting for start with the switch off.
// ---------------------------------------------------------------------------
module load_switch_soft_start_trip
    import lsst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_enable_request,
    input  logic [CUR_W-1:0] i_measured_current,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_power_on,
    output logic [2:0]       o_phase,
    output logic [CUR_W-1:0] o_peak_current,
    output logic [CNT_W-1:0] o_over_limit_ticks,
    input  logic             i_cfg_wr_en,
    input  logic [CUR_W-1:0] i_cfg_wr_data
);

    logic               r_in_valid;
    logic               r_in_en;
    logic [CUR_W-1:0]   r_in_cur;
    logic               r_out_valid;
    logic [CUR_W-1:0]   r_limit;

    t_phase             r_phase,        n_phase;
    logic [CNT_W-1:0]   r_switch_delay, n_switch_delay;
    logic [PULSE_W-1:0] r_pulses_left,  n_pulses_left;
    logic [CNT_W-1:0]   r_over_count,   n_over_count;
    logic [CUR_W-1:0]   r_peak,         n_peak;
    logic               r_switch,       n_switch;

    logic               advance;
    logic               in_take;
    logic [CNT_W-1:0]   over_inc;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_take = i_valid && o_ready;

    always_comb begin
        n_phase        = r_phase;
        n_switch_delay = r_switch_delay;
        n_pulses_left  = r_pulses_left;
        n_over_count   = r_over_count;
        n_peak         = r_peak;
        n_switch       = r_switch;
        over_inc       = (r_over_count < OVER_COUNT_MAX) ? r_over_count + 7'd1
                                                         : r_over_count;
        case (r_phase)
            PH_WAIT: begin
                if (r_switch_delay != '0) begin
                    n_switch_delay = r_switch_delay - 7'd1;
                end else if (r_in_en) begin
                    n_switch = 1'b1;
                    n_phase  = PH_PULSE;
                end
            end
            PH_PULSE: begin
                if (r_switch_delay != '0) begin
                    n_switch_delay = r_switch_delay - 7'd1;
                end else begin
                    n_switch = 1'b0;
                    if (r_pulses_left == '0) begin
                        n_phase = PH_FINAL;
                    end else begin
                        n_pulses_left = r_pulses_left - 5'd1;
                        n_phase       = PH_WAIT;
                    end
                end
            end
            PH_FINAL: begin
                if (r_switch_delay != '0) begin
                    n_switch_delay = r_switch_delay - 7'd1;
                end else begin
                    n_switch = 1'b1;
                    n_phase  = PH_RUN;
                end
            end
            PH_OFF: begin
                if (r_in_en) begin
                    if (r_over_count == '0) begin
                        n_phase        = PH_WAIT;
                        n_pulses_left  = SOFT_START_PULSES;
                        n_switch_delay = RESTART_DELAY;
                    end else begin
                        n_over_count = r_over_count - 7'd1;
                    end
                end
            end
            PH_RUN: begin
                if (!r_in_en) begin
                    n_phase  = PH_OFF;
                    n_switch = 1'b0;
                end else begin
                    if (r_in_cur > r_limit) begin
                        n_over_count = over_inc;
                        // The trip looks at the count including this tick.
                        if (over_inc > TRIP_TICKS) begin
                            n_phase  = PH_OFF;
                            n_switch = 1'b0;
                        end
                    end else begin
                        n_over_count = '0;
                    end
                    if (r_in_cur > r_peak) begin
                        n_peak = r_in_cur;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_limit        <= CURRENT_LIMIT_RST;
            r_phase        <= PH_WAIT;
            r_switch_delay <= '0;
            r_pulses_left  <= SOFT_START_PULSES;
            r_over_count   <= '0;
            r_peak         <= '0;
            r_switch       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid    <= 1'b1;
                r_phase        <= n_phase;
                r_switch_delay <= n_switch_delay;
                r_pulses_left  <= n_pulses_left;
                r_over_count   <= n_over_count;
                r_peak         <= n_peak;
                r_switch       <= n_switch;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_en  <= i_enable_request;
            r_in_cur <= i_measured_current;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_power_on         = r_switch;
    assign o_phase            = 3'(r_phase);
    assign o_peak_current     = r_peak;
    assign o_over_limit_ticks = r_over_count;

endmodule

// ----- hdl/lsst_checker.sv -----
// ---------------------------------------------------------------------------
// lsst_checker
// Port-level checks for the load switch controller, bound to the top level.
// ---------------------------------------------------------------------------
module lsst_checker
    import lsst_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_ready,
    input logic             o_power_on,
    input logic [2:0]       o_phase,
    input logic [CUR_W-1:0] o_peak_current,
    input logic [CNT_W-1:0] o_over_limit_ticks
);

    // The switch is on exactly in the pulse-on and running phases.
    a_switch_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_power_on == ((o_phase == 3'(PH_PULSE)) || (o_phase == 3'(PH_RUN)))))
        else $error("switch level does not match phase");

    // The trip fires one tick past the threshold, so the count never goes further.
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_over_limit_ticks <= TRIP_TICKS + 7'd1))
        else $error("over-current count beyond trip point");

    // The peak is only ever raised.
    a_peak_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (o_peak_current >= $past(o_peak_current)))
        else $error("peak current decreased");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_power_on) && $stable(o_phase)
            && $stable(o_peak_current) && $stable(o_over_limit_ticks)))
        else $error("stalled result changed");

endmodule

bind load_switch_soft_start_trip lsst_checker u_lsst_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_power_on         (o_power_on),
    .o_phase            (o_phase),
    .o_peak_current     (o_peak_current),
    .o_over_limit_ticks (o_over_limit_ticks)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the load switch controller. Tick requests carry the
// enable and the measured current; every accepted request is run through a
// local prediction of the soft start, trip and hiccup behaviour and each
// result is compared field by field, in order, with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;
    import lsst_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic             power_on;
        t_phase           phase;
        logic [CUR_W-1:0] peak_current;
        logic [CNT_W-1:0] over_limit_ticks;
    } t_tick_result;

    typedef enum {RG_UNDER, RG_OVER, RG_NOISY, RG_DROP} t_regime;
    typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} t_stall_mode;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic             i_enable_request;
    logic [CUR_W-1:0] i_measured_current;
    logic             o_valid;
    logic             i_ready;
    logic             o_power_on;
    logic [2:0]       o_phase;
    logic [CUR_W-1:0] o_peak_current;
    logic [CNT_W-1:0] o_over_limit_ticks;
    logic             i_cfg_wr_en;
    logic [CUR_W-1:0] i_cfg_wr_data;

    // Predicted controller state and the current limit register.
    t_phase             ph;
    logic [CNT_W-1:0]   hold_delay;
    logic [PULSE_W-1:0] pulses_rem;
    logic [CNT_W-1:0]   over_cnt;
    logic [CUR_W-1:0]   peak_mA;
    logic               sw_on;
    logic [CUR_W-1:0]   limit_mA;

    t_tick_result pending_results[$];

    int cycle_count     = 0;
    int ticks_sent      = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int trips_seen      = 0;
    int starts_done     = 0;
    int limits_used     = 0;
    int burst_left      = 0;
    int stall_left      = 0;
    t_stall_mode stall_mode = STALL_NONE;

    load_switch_soft_start_trip dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_enable_request   (i_enable_request),
        .i_measured_current (i_measured_current),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_power_on         (o_power_on),
        .o_phase            (o_phase),
        .o_peak_current     (o_peak_current),
        .o_over_limit_ticks (o_over_limit_ticks),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // One control tick of the switch controller.
    function automatic t_tick_result advance_switch(input logic en,
                                                    input logic [CUR_W-1:0] cur);
        t_tick_result r;
        case (ph)
            PH_WAIT: begin
                if (hold_delay != '0) begin
                    hold_delay = hold_delay - 7'd1;
                end else if (en) begin
                    sw_on = 1'b1;
                    ph    = PH_PULSE;
                end
            end
            PH_PULSE: begin
                if (hold_delay != '0) begin
                    hold_delay = hold_delay - 7'd1;
                end else begin
                    sw_on = 1'b0;
                    if (pulses_rem == '0) begin
                        ph = PH_FINAL;
                    end else begin
                        pulses_rem = pulses_rem - 5'd1;
                        ph         = PH_WAIT;
                    end
                end
            end
            PH_FINAL: begin
                if (hold_delay != '0) begin
                    hold_delay = hold_delay - 7'd1;
                end else begin
                    sw_on = 1'b1;
                    ph    = PH_RUN;
                    starts_done++;
                end
            end
            PH_OFF: begin
                // Without enable the off-wait count simply holds.
                if (en) begin
                    if (over_cnt == '0) begin
                        ph         = PH_WAIT;
                        pulses_rem = SOFT_START_PULSES;
                        hold_delay = RESTART_DELAY;
                    end else begin
                        over_cnt = over_cnt - 7'd1;
                    end
                end
            end
            PH_RUN: begin
                if (!en) begin
                    ph    = PH_OFF;
                    sw_on = 1'b0;
                end else begin
                    if (cur > limit_mA) begin
                        if (over_cnt < OVER_COUNT_MAX) over_cnt = over_cnt + 7'd1;
                        if (over_cnt > TRIP_TICKS) begin
                            ph    = PH_OFF;
                            sw_on = 1'b0;
                            trips_seen++;
                        end
                    end else begin
                        over_cnt = '0;
                    end
                    if (cur > peak_mA) peak_mA = cur;
                end
            end
            default: ;
        endcase
        r.power_on         = sw_on;
        r.phase            = ph;
        r.peak_current     = peak_mA;
        r.over_limit_ticks = over_cnt;
        return r;
    endfunction

    // Results are checked before new requests are predicted, so a result can
    // never be matched against the request accepted on the same edge.
    always @(posedge i_clk) begin
        t_tick_result exp_r;
        if (i_rst_n) begin
            if (i_cfg_wr_en) limit_mA = i_cfg_wr_data;
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    mismatch_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    results_checked++;
                    if (o_power_on !== exp_r.power_on) begin
                        $error("power_on: expected %0d, actual %0d",
                               exp_r.power_on, o_power_on);
                        mismatch_count++;
                    end
                    if (o_phase !== exp_r.phase) begin
                        $error("phase: expected %0d, actual %0d", exp_r.phase, o_phase);
                        mismatch_count++;
                    end
                    if (o_peak_current !== exp_r.peak_current) begin
                        $error("peak_current: expected %0d, actual %0d",
                               exp_r.peak_current, o_peak_current);
                        mismatch_count++;
                    end
                    if (o_over_limit_ticks !== exp_r.over_limit_ticks) begin
                        $error("over_limit_ticks: expected %0d, actual %0d",
                               exp_r.over_limit_ticks, o_over_limit_ticks);
                        mismatch_count++;
                    end
                end
            end
            if (i_valid && o_ready)
                pending_results.push_back(advance_switch(i_enable_request,
                                                         i_measured_current));
        end
    end

    // The output side runs through spells of full rate, random stalls and a
    // fixed stall pattern.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 2));
                stall_left = $urandom_range(64, 256);
            end
            stall_left--;
            case (stall_mode)
                STALL_NONE:   i_ready <= 1'b1;
                STALL_RANDOM: i_ready <= ($urandom_range(0, 3) != 0);
                default:      i_ready <= ((cycle_count % 7) < 4);
            endcase
        end
    end

    task automatic send_tick(input logic en, input logic [CUR_W-1:0] cur);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid            <= 1'b1;
        i_enable_request   <= en;
        i_measured_current <= cur;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        ticks_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_current_limit(input logic [CUR_W-1:0] value);
        wait_for_results();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        limits_used++;
    endtask

    // Without enable the controller must sit in wait start with the switch off.
    task automatic test_wait_disabled();
        send_tick(1'b0, 16'h0000);
        send_tick(1'b0, 16'hFFFF);
        send_tick(1'b0, 16'hAAAA);
        send_tick(1'b0, 16'h5555);
        send_tick(1'b0, limit_mA);
        send_tick(1'b0, limit_mA + 16'd1);
    endtask

    // Enable held through the whole pulse train and into the running phase.
    task automatic test_power_up();
        repeat (45) send_tick(1'b1, CUR_W'($urandom_range(0, 2000)));
    endtask

    // Current equal to the limit clears the count, one above it counts.
    task automatic test_limit_boundary();
        send_tick(1'b1, limit_mA);
        send_tick(1'b1, limit_mA + 16'd1);
        send_tick(1'b1, limit_mA + 16'd1);
        send_tick(1'b1, limit_mA);
        send_tick(1'b1, 16'h0000);
        send_tick(1'b1, limit_mA + 16'd1);
        send_tick(1'b1, limit_mA + 16'd1);
    endtask

    // Dropping enable turns the switch off and the count is then held.
    task automatic test_enable_drop();
        repeat (3) send_tick(1'b0, 16'hFFFF);
    endtask

    // With a zero limit every non-zero current counts, so a full restart,
    // a trip and a hiccup back to running follow from a steady enable.
    task automatic test_trip_hiccup();
        set_current_limit('0);
        repeat (260) send_tick(1'b1, CUR_W'($urandom_range(1, 2000)));
        repeat (8) send_tick(1'b0, CUR_W'($urandom_range(0, 2000)));
        repeat (240) send_tick(1'b1, CUR_W'($urandom_range(0, 2000)));
    endtask

    // Mostly well-formed stretches (enable held with currents under or over
    // the limit), broken up by noisy ticks and short enable drops.
    task automatic run_regimes(input int n_ticks, input int unsigned cap);
        t_regime          kind;
        int               len;
        int               sent;
        int unsigned      lim;
        logic             en;
        logic [CUR_W-1:0] cur;
        sent = 0;
        lim  = 32'(limit_mA);
        while (sent < n_ticks) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: kind = RG_UNDER;
                4, 5:       kind = RG_OVER;
                6, 7:       kind = RG_NOISY;
                default:    kind = RG_DROP;
            endcase
            case (kind)
                RG_UNDER: len = $urandom_range(10, 80);
                RG_OVER:  len = $urandom_range(0, 1) ? $urandom_range(1, 20)
                                                     : $urandom_range(95, 110);
                RG_NOISY: len = $urandom_range(1, 12);
                default:  len = $urandom_range(1, 6);
            endcase
            repeat (len) begin
                case (kind)
                    RG_UNDER: begin
                        en  = 1'b1;
                        cur = CUR_W'($urandom_range(0, (lim < cap) ? lim : cap));
                    end
                    RG_OVER: begin
                        en  = 1'b1;
                        cur = (lim < cap) ? CUR_W'($urandom_range(lim + 1, cap))
                                          : CUR_W'($urandom_range(0, cap));
                    end
                    RG_NOISY: begin
                        en  = 1'($urandom_range(0, 1));
                        cur = CUR_W'($urandom_range(0, cap));
                    end
                    default: begin
                        en  = 1'b0;
                        cur = CUR_W'($urandom_range(0, cap));
                    end
                endcase
                send_tick(en, cur);
                sent++;
            end
        end
    endtask

    // Peak tracking is kept low at first so that later, larger currents still
    // move it; the full current range is used in the two later runs.
    task automatic test_random_regimes();
        set_current_limit(CUR_W'($urandom_range(200, 1500)));
        run_regimes(130, 4000);
        set_current_limit(16'hFFFF);
        run_regimes(130, 65535);
        set_current_limit(CUR_W'($urandom_range(0, 65535)));
        run_regimes(130, 65535);
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_enable_request   = 1'b0;
        i_measured_current = '0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_wr_data      = '0;
        ph                 = PH_WAIT;
        hold_delay         = '0;
        pulses_rem         = SOFT_START_PULSES;
        over_cnt           = '0;
        peak_mA            = '0;
        sw_on              = 1'b0;
        limit_mA           = CURRENT_LIMIT_RST;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_wait_disabled();
        test_power_up();
        test_limit_boundary();
        test_enable_drop();
        test_trip_hiccup();
        test_random_regimes();

        wait_for_results();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d ticks and checked %0d results across %0d limit settings.",
                 ticks_sent, results_checked, limits_used + 1);
        $display("Saw %0d completed soft starts and %0d over-current trips.",
                 starts_done, trips_seen);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
